[rtl/indexed_list_insert_remove_defines.svh]
// ----------------------------------------------------------------------------
// Indexed list assertion macros
// Shared property templates, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_INSERT_REMOVE_DEFINES_SVH
`define INDEXED_LIST_INSERT_REMOVE_DEFINES_SVH

// Same-cycle implication.
`define ILIR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("indexed list assertion failed");

// Next-cycle implication.
`define ILIR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("indexed list assertion failed");

`endif

[rtl/ilir_pkg.sv]
// ----------------------------------------------------------------------------
// Indexed list package
// Sizes, operation and status codes, and the control bundle sent to the cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ilir_pkg;

  localparam int DEPTH     = 64;
  localparam int WORD_BITS = 32;

  localparam int KIND_W    = 3;
  localparam int POS_W     = 7;
  localparam int DATA_IN_W = 32;
  localparam int DATA_OUT_W = 32;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 7;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  // Read gather: first level ORs groups of GRP taps, second level the groups.
  localparam int GRP   = 8;
  localparam int NGRP  = (DEPTH + GRP - 1) / GRP;
  localparam int TAP_N = NGRP * GRP;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [KIND_W-1:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_READ   = 3'd2,
    OP_WRITE  = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic             ins;
    logic             rem;
    logic             wr;
    logic [CMP_W-1:0] pos;
    word_t            word;
  } cell_ctrl_t;

  function automatic word_t fit_word(input logic [DATA_IN_W-1:0] d);
    logic [DATA_IN_W+WORD_BITS-1:0] t;
    t = {{WORD_BITS{1'b0}}, d};
    return t[WORD_BITS-1:0];
  endfunction

  function automatic logic [DATA_OUT_W-1:0] word_to_out(input word_t w);
    logic [DATA_OUT_W+WORD_BITS-1:0] t;
    t = {{DATA_OUT_W{1'b0}}, w};
    return t[DATA_OUT_W-1:0];
  endfunction

  function automatic logic [COUNT_W-1:0] fit_count(input logic [CNT_W-1:0] c);
    logic [CNT_W+COUNT_W-1:0] t;
    t = {{COUNT_W{1'b0}}, c};
    return t[COUNT_W-1:0];
  endfunction

endpackage

`default_nettype wire

[rtl/ilir_cell.sv]
// ----------------------------------------------------------------------------
// Indexed list cell
// One list slot: holds a word, shifts up or down with its neighbors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ilir_cell
  import ilir_pkg::*;
(
  input  wire logic             clk,
  input  wire cell_ctrl_t       ctrl,
  input  wire logic [CMP_W-1:0] idx,
  input  wire word_t            left,
  input  wire word_t            right,
  output word_t                 q,
  output word_t                 tap
);

  word_t q_r;
  word_t q_nxt;
  logic  gt;
  logic  eq;

  assign gt = idx > ctrl.pos;
  assign eq = idx == ctrl.pos;

  always_comb begin
    q_nxt = q_r;
    if (ctrl.ins) begin
      if (gt) begin
        q_nxt = left;
      end else if (eq) begin
        q_nxt = ctrl.word;
      end
    end
    if (ctrl.rem && (gt || eq)) begin
      q_nxt = right;
    end
    if (ctrl.wr && eq) begin
      q_nxt = ctrl.word;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q   = q_r;
  assign tap = eq ? q_r : '0;

endmodule

`default_nettype wire

[rtl/ilir_gather.sv]
// ----------------------------------------------------------------------------
// Indexed list read gather
// Registered OR tree that collects the one selected cell word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ilir_gather
  import ilir_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  load,
  input  wire word_t taps [TAP_N],
  output word_t      rd
);

  word_t grp_r   [NGRP];
  word_t grp_nxt [NGRP];

  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    always_comb begin
      grp_nxt[g] = '0;
      for (int k = 0; k < GRP; k++) begin
        grp_nxt[g] = grp_nxt[g] | taps[g*GRP + k];
      end
    end

    always_ff @(posedge clk) begin
      if (load) begin
        grp_r[g] <= grp_nxt[g];
      end
    end
  end

  always_comb begin
    rd = '0;
    for (int g = 0; g < NGRP; g++) begin
      rd = rd | grp_r[g];
    end
  end

endmodule

`default_nettype wire

[rtl/indexed_list_insert_remove.sv]
// ----------------------------------------------------------------------------
// Indexed list with insert and remove at a position
// Ordered list of DEPTH words in a row of shifting cells, one result per item.
// ----------------------------------------------------------------------------
// Each input item is one operation (insert, remove, read, write, clear) and
// yields exactly one result item with the word read, a status and the count
// after the operation. Insert and remove shift the whole row of cells by one
// place at once. Each item is handled in the accept cycle, which updates the
// cells and latches the first level of the read OR tree, and then in the reduce
// state, which folds the groups and loads the output register once it is free.
// The block then takes the next item while that result may still wait at the
// output. No new item is taken while in reduce, set by the two-level read gather.
// Entries need no clearing after reset; only the count, state and output valid reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "indexed_list_insert_remove_defines.svh"

module indexed_list_insert_remove
  import ilir_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: kind [2:0], position [9:3], data_in [41:10], zero fill [47:42]
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,
  // out_tdata: data_out [31:0], status [33:32], count [40:34], zero fill [47:41]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata
);

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_REDUCE = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]    count_r, count_nxt;
  status_t             pend_status_r, pend_status_nxt;
  logic                read_ok_r, read_ok_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [DATA_OUT_W-1:0] out_data_r;
  status_t             out_status_r;
  logic [COUNT_W-1:0]  out_count_r;

  logic                acc;
  logic                out_load;
  logic [KIND_W-1:0]   in_kind;
  logic [POS_W-1:0]    in_position;
  logic [DATA_IN_W-1:0] in_data_in;
  logic [CMP_W-1:0]    posx;
  logic [CMP_W-1:0]    cntx;
  cell_ctrl_t          ctl;

  word_t cell_q   [DEPTH];
  word_t taps_pad [TAP_N];
  word_t rd;

  // Unpack the input item.
  assign in_kind     = in_tdata[2:0];
  assign in_position = in_tdata[9:3];
  assign in_data_in  = in_tdata[41:10];

  assign in_tready = (state_r == S_IDLE);
  assign acc       = in_tvalid && in_tready;

  assign posx = CMP_W'(in_position);
  assign cntx = CMP_W'(count_r);

  // Decode the operation; cells move only on an accepted, in-range item (an insert also needs room).
  always_comb begin
    ctl             = '0;
    ctl.pos         = posx;
    ctl.word        = fit_word(in_data_in);
    count_nxt       = count_r;
    pend_status_nxt = pend_status_r;
    read_ok_nxt     = read_ok_r;
    if (acc) begin
      pend_status_nxt = ST_OK;
      read_ok_nxt     = 1'b0;
      case (op_t'(in_kind))
        OP_INSERT: begin
          if (posx > cntx) begin
            pend_status_nxt = ST_RANGE;
          end else if (count_r == CNT_W'(DEPTH)) begin
            pend_status_nxt = ST_FULL;
          end else begin
            ctl.ins   = 1'b1;
            count_nxt = count_r + 1'b1;
          end
        end
        OP_REMOVE: begin
          if (posx >= cntx) begin
            pend_status_nxt = ST_RANGE;
          end else begin
            ctl.rem   = 1'b1;
            count_nxt = count_r - 1'b1;
          end
        end
        OP_READ: begin
          if (posx >= cntx) begin
            pend_status_nxt = ST_RANGE;
          end else begin
            read_ok_nxt = 1'b1;
          end
        end
        OP_WRITE: begin
          if (posx >= cntx) begin
            pend_status_nxt = ST_RANGE;
          end else begin
            ctl.wr = 1'b1;
          end
        end
        OP_CLEAR: begin
          count_nxt = '0;
        end
        default: begin
          // Unused kinds leave the list alone and report ok.
        end
      endcase
    end
  end

  // Row of cells; the ends see zero on the left and their own word on the right.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    word_t left_w;
    word_t right_w;
    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_w = cell_q[i];
    end else begin : g_mid_r
      assign right_w = cell_q[i+1];
    end
    ilir_cell u_cell (
      .clk   (clk),
      .ctrl  (ctl),
      .idx   (CMP_W'(i)),
      .left  (left_w),
      .right (right_w),
      .q     (cell_q[i]),
      .tap   (taps_pad[i])
    );
  end

  // Pad the tap row out to whole groups.
  for (genvar i = DEPTH; i < TAP_N; i++) begin : g_pad
    assign taps_pad[i] = '0;
  end

  // Latch the group ORs at accept, before the cells change.
  ilir_gather u_gather (
    .clk  (clk),
    .load (acc),
    .taps (taps_pad),
    .rd   (rd)
  );

  // Hold in reduce until the output register is free.
  assign out_load = (state_r == S_REDUCE) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (acc) begin
          state_nxt = S_REDUCE;
        end
      end
      S_REDUCE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    pend_status_r <= pend_status_nxt;
    read_ok_r     <= read_ok_nxt;
    if (out_load) begin
      out_data_r   <= read_ok_r ? word_to_out(rd) : '0;
      out_status_r <= pend_status_r;
      out_count_r  <= fit_count(count_r);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_count_r, out_status_r, out_data_r};

  `ILIR_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CNT_W'(DEPTH))
  `ILIR_ASSERT_NXT(a_accept_reduce, acc, state_r == S_REDUCE)
  `ILIR_ASSERT_NXT(a_insert_count, acc && ctl.ins, count_r == CNT_W'($past(count_r) + 1'b1))
  `ILIR_ASSERT_IMP(a_single_op, acc, $onehot0({ctl.ins, ctl.rem, ctl.wr}))

endmodule

`default_nettype wire

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// Indexed list testbench
// Drives list operations over the input stream and checks every result item
// against a local copy of the list, with random stalls on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import ilir_pkg::*;

  // Stop the run here if it hangs; far above the slowest legal run.
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [DATA_OUT_W-1:0] data_out;
    logic [STATUS_W-1:0]   status;
    logic [COUNT_W-1:0]    count;
  } list_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  // in_tdata: kind [2:0], position [9:3], data_in [41:10], zero fill [47:42]
  logic [47:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // out_tdata: data_out [31:0], status [33:32], count [40:34], zero fill [47:41]
  logic [47:0] out_tdata;

  // Local copy of the list, updated as each item is accepted.
  word_t        list_words [DEPTH];
  int           list_len = 0;
  list_result_t expected_results [$];

  int fail_count      = 0;
  int cycle_count     = 0;
  bit sender_idles    = 1'b0;
  bit receiver_idles  = 1'b0;
  int hold_off_cycles = 0;
  int rx_gap          = 0;

  indexed_list_insert_remove dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Apply one operation to the local list and return the result it yields.
  function automatic list_result_t apply_list_op(input logic [KIND_W-1:0] kind,
                                                 input logic [POS_W-1:0] pos,
                                                 input logic [DATA_IN_W-1:0] data_in);
    list_result_t r;
    word_t        w;
    r = '0;
    r.status = ST_OK;
    w = data_in[WORD_BITS-1:0];
    case (kind)
      OP_INSERT: begin
        // Past-the-end check wins over the full check.
        if (pos > list_len) begin
          r.status = ST_RANGE;
        end else if (list_len >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (int i = list_len; i > pos; i--) list_words[i] = list_words[i-1];
          list_words[pos] = w;
          list_len++;
        end
      end
      OP_REMOVE: begin
        if (pos >= list_len) begin
          r.status = ST_RANGE;
        end else begin
          for (int i = pos; i + 1 < list_len; i++) list_words[i] = list_words[i+1];
          list_len--;
        end
      end
      OP_READ: begin
        if (pos >= list_len) r.status = ST_RANGE;
        else r.data_out = DATA_OUT_W'(list_words[pos]);
      end
      OP_WRITE: begin
        if (pos >= list_len) r.status = ST_RANGE;
        else list_words[pos] = w;
      end
      OP_CLEAR: begin
        list_len = 0;
      end
      default: begin
        // Unused kinds leave the list alone and report ok.
      end
    endcase
    r.count = COUNT_W'(list_len);
    return r;
  endfunction

  // Offer one item, hold it until accepted, then queue its expected result.
  task automatic send_op(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                         input logic [DATA_IN_W-1:0] data_in);
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, data_in, pos, kind};
    do @(posedge clk); while (!in_tready);
    expected_results.push_back(apply_list_op(kind, pos, data_in));
  endtask

  // Drop valid between items so the next item starts in a fresh step.
  task automatic idle_input();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Receiver: a long hold-off first, then short random stall bursts.
  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles--;
      out_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_tready <= 1'b0;
    end else if (receiver_idles && $urandom_range(0, 4) == 0) begin
      rx_gap = $urandom_range(1, 12) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin : check_results
    list_result_t want;
    list_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.data_out = out_tdata[31:0];
      got.status   = out_tdata[33:32];
      got.count    = out_tdata[40:34];
      if (expected_results.size() == 0) begin
        $error("result with no item pending: data_out %h status %0d count %0d",
               got.data_out, got.status, got.count);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (got.data_out !== want.data_out) begin
          $error("data_out: expected %h, got %h", want.data_out, got.data_out);
          fail_count++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          fail_count++;
        end
        if (got.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, got.count);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: end the run if it overruns the cycle budget.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  task automatic apply_reset();
    rst_n <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
  endtask

  // Every operation against an empty list, plus an unused kind.
  task automatic test_empty_list();
    send_op(OP_READ,   0, 32'h1234_5678);
    send_op(OP_REMOVE, 0, 32'h0);
    send_op(OP_WRITE,  0, 32'hDEAD_BEEF);
    send_op(OP_INSERT, 1, 32'h1111_1111);   // past the end of an empty list
    send_op(KIND_W'(OP_CLEAR + 3), 0, 32'hFFFF_FFFF);
    send_op(OP_CLEAR,  0, 32'h0);
    idle_input();
  endtask

  // Insert at front, middle and end; read, write and remove at the edges.
  task automatic test_edit_ops();
    send_op(OP_INSERT, 0, 32'h0000_0000);
    send_op(OP_INSERT, 1, 32'hFFFF_FFFF);   // append
    send_op(OP_INSERT, 0, 32'hA5A5_A5A5);   // front
    send_op(OP_INSERT, 1, 32'h5A5A_5A5A);   // middle
    for (int i = 0; i < 4; i++) send_op(OP_READ, POS_W'(i), 32'h0);
    send_op(OP_WRITE,  3, 32'h0F0F_0F0F);
    send_op(OP_READ,   3, 32'h0);
    send_op(OP_READ,   4, 32'h0);           // one past the last entry
    send_op(OP_REMOVE, 3, 32'h0);           // last entry
    send_op(OP_REMOVE, 0, 32'h0);           // first entry
    send_op(OP_READ,   127, 32'h0);
    send_op(OP_WRITE,  64, 32'hFFFF_FFFF);
    send_op(OP_REMOVE, 64, 32'h0);
    send_op(KIND_W'(OP_CLEAR + 1), 1, 32'h0);
    send_op(OP_READ,   0, 32'h0);
    idle_input();
  endtask

  // Fill to capacity with random content, then probe the full and range cases.
  task automatic test_full_list();
    send_op(OP_CLEAR, 0, 32'h0);
    while (list_len < DEPTH)
      send_op(OP_INSERT, POS_W'($urandom_range(0, list_len)), $urandom);
    send_op(OP_INSERT, 0, $urandom);                  // full
    send_op(OP_INSERT, POS_W'(DEPTH + 1), $urandom);  // range check beats full
    send_op(OP_INSERT, POS_W'(DEPTH), $urandom);      // append when full
    send_op(OP_READ,   POS_W'(DEPTH - 1), 32'h0);
    send_op(OP_READ,   POS_W'(DEPTH), 32'h0);
    send_op(OP_REMOVE, POS_W'(DEPTH - 1), 32'h0);
    send_op(OP_INSERT, POS_W'(DEPTH - 1), 32'hFFFF_FFFF);
    for (int i = 0; i < 8; i++) send_op(OP_READ, POS_W'($urandom_range(0, DEPTH - 1)), 32'h0);
    send_op(OP_CLEAR, 0, 32'h0);
    send_op(OP_READ,  0, 32'h0);
    idle_input();
  endtask

  // Hold the result side off for a long stretch while items keep coming,
  // so the block fills and drops in_tready.
  task automatic test_output_backpressure();
    hold_off_cycles = 300;
    for (int i = 0; i < 16; i++)
      send_op(OP_INSERT, POS_W'($urandom_range(0, list_len)), $urandom);
    idle_input();
    wait_drained();
  endtask

  // Mostly well-formed positions with random data; the insert/remove balance
  // swings per segment so the list runs between empty and full.
  task automatic test_random_ops(input int n_items, input bit allow_idle);
    int                  grow_bias;
    int                  roll;
    logic [KIND_W-1:0]   kind;
    logic [POS_W-1:0]    pos;
    for (int k = 0; k < n_items; k++) begin
      if (k % 150 == 0) begin
        grow_bias      = $urandom_range(10, 90);
        sender_idles   = allow_idle && ($urandom_range(0, 3) != 0);
        receiver_idles = allow_idle && ($urandom_range(0, 3) != 0);
      end
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        kind = OP_CLEAR;
      end else if (roll < 4) begin
        kind = KIND_W'(OP_CLEAR + $urandom_range(1, 3));   // unused kinds
      end else begin
        roll = $urandom_range(0, 149);
        if (roll < grow_bias) kind = OP_INSERT;
        else if (roll < 100) kind = OP_REMOVE;
        else if (roll < 125) kind = OP_READ;
        else kind = OP_WRITE;
      end
      if ($urandom_range(0, 99) < 15) pos = POS_W'($urandom_range(0, 127));
      else if (kind == OP_INSERT) pos = POS_W'($urandom_range(0, list_len));
      else if (list_len > 0) pos = POS_W'($urandom_range(0, list_len - 1));
      else pos = '0;
      send_op(kind, pos, $urandom);
    end
    idle_input();
  endtask

  initial begin
    apply_reset();
    test_empty_list();
    test_edit_ops();
    test_full_list();
    test_output_backpressure();
    test_random_ops(1400, 1'b1);
    // Close with a stretch at full rate, no idling on either side.
    test_random_ops(200, 1'b0);
    sender_idles   = 1'b0;
    receiver_idles = 1'b0;
    wait_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
